[rtl/fbpa_pkg.sv]
// Shared widths, codes, reset values and divider transaction types of the block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;

    localparam int ADDR_W    = 32;
    localparam int REQ_W     = 17;
    localparam int ALIGN_W   = 13;
    localparam int EBB_W     = 18;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + EBB_W;

    localparam int DIV_STEPS = ADDR_W;
    localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);

    // Register values after reset, and the pool that a clear would build from them
    localparam int RST_BASE  = 0;
    localparam int RST_TOTAL = 4096;
    localparam int RST_BLOCK = 64;
    localparam int RST_ALIGN = 8;
    localparam int RST_REM   = RST_BASE % RST_ALIGN;
    localparam int RST_ADJ   = (RST_REM == 0) ? 0 : RST_ALIGN - RST_REM;
    localparam int RST_EBB   = ((RST_BLOCK + RST_ALIGN - 1) / RST_ALIGN) * RST_ALIGN;
    localparam int RST_NBLK  = (RST_TOTAL < RST_ADJ) ? 0 : (RST_TOTAL - RST_ADJ) / RST_EBB;
    localparam int RST_COUNT = (RST_NBLK > MAX_BLOCKS) ? MAX_BLOCKS : RST_NBLK;
    localparam int RST_FIRST = RST_BASE + RST_ADJ;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SIZE  = 2'd2,
        ST_ALIGN = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE  = 2'd0,
        REG_TOTAL = 2'd1,
        REG_BLOCK = 2'd2,
        REG_ALIGN = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [EBB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
        logic [EBB_W-1:0]  remainder;
    } div_rsp_t;

endpackage

[rtl/fbpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/fbpa_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module fbpa_div import fbpa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIVCNT_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   q_reg, q_next;
    logic [EBB_W-1:0]    r_reg, r_next;
    logic [EBB_W-1:0]    d_reg, d_next;

    logic [EBB_W:0]      trial;
    logic [EBB_W:0]      diff;
    logic                ge;

    always_comb
    begin
        trial = {r_reg, q_reg[ADDR_W-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = (trial >= {1'b0, d_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVCNT_W'(DIV_STEPS);
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            r_next   = ge ? diff[EBB_W-1:0] : trial[EBB_W-1:0];
            q_next   = {q_reg[ADDR_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

[rtl/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed-size block pool allocator with a last-in first-out freed list.
//
// Transactions arrive on the input channel (in_valid/in_ready) as allocate, free or
// clear, and each gives exactly one result transaction on the output channel
// (out_valid/out_ready): block address, status and bytes in use afterwards.
// Registers are written through cfg_write/cfg_index/cfg_data and take effect at
// the next clear, except the alignment register, which the allocate alignment
// check reads at once. One transaction is worked at a time; in_ready is high only
// while the block waits for work. An allocate refused by a size or alignment
// check, or out of blocks, goes straight to its result; one that hands out a block
// passes a multiply and an add, after a stack read when it reuses a freed block.
// A free runs the 32-step serial divider; a clear makes three passes through the
// same divider, skipping the last when the alignment adjustment exceeds the region.
// in_ready rises only after the result has entered the output register, so the
// next transaction is taken after that.
// A result waits in the output register while the receiver stalls; the next
// input transaction is still accepted, and its result is held back until the
// waiting one is taken. Reset loads the register reset values and the pool that a
// clear builds from them; no clearing pass is needed as the freed stack is only
// ever read at entries already written.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [ADDR_W-1:0]    free_address,
    input  logic [REQ_W-1:0]     request_bytes,
    input  logic [ALIGN_W-1:0]   request_alignment,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    block_address,
    output logic [STAT_W-1:0]    status,
    output logic [ADDR_W-1:0]    used_bytes
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_ADD  = 9'b000000100,
        S_FDIV = 9'b000001000,
        S_CREM = 9'b000010000,
        S_CRND = 9'b000100000,
        S_CSUB = 9'b001000000,
        S_CDIV = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;

    logic [ADDR_W-1:0]   cfg_base_reg;
    logic [ADDR_W-1:0]   cfg_total_reg;
    logic [REQ_W-1:0]    cfg_block_reg;
    logic [ALIGN_W-1:0]  cfg_align_reg;

    logic [CNT_W-1:0]    freed_count_reg, freed_count_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic [CNT_W-1:0]    block_count_reg, block_count_next;
    logic [EBB_W-1:0]    ebb_reg, ebb_next;
    logic [ADDR_W-1:0]   first_reg, first_next;
    logic [ADDR_W-1:0]   used_reg, used_next;

    logic [ALIGN_W-1:0]  adj_reg, adj_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                pop_reg, pop_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]   block_reg, block_next;
    status_t             status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_block_reg;
    status_t             out_status_reg;
    logic [ADDR_W-1:0]   out_used_reg;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [IDX_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_data;

    logic                accept;
    logic                load_out;
    logic [ALIGN_W-1:0]  aval;
    logic [REQ_W-1:0]    req_one;
    logic [CNT_W-1:0]    cnt_dec;
    logic [IDX_W-1:0]    mul_idx;
    logic [ALIGN_W-1:0]  crem_rem;
    logic [ALIGN_W-1:0]  crem_adj;
    logic [EBB_W+ALIGN_W-1:0] rnd_prod;
    logic [ADDR_W:0]     used_sum;
    logic [ADDR_W-1:0]   used_sub;
    logic [ADDR_W-1:0]   sat_count;

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        aval      = (cfg_align_reg == '0) ? ALIGN_W'(1) : cfg_align_reg;
        req_one   = (cfg_block_reg == '0) ? REQ_W'(1) : cfg_block_reg;
        cnt_dec   = freed_count_reg - 1'b1;
        mul_idx   = pop_reg ? ram_rd_data : idx_reg;
        crem_rem  = div_rsp.remainder[ALIGN_W-1:0];
        crem_adj  = (crem_rem == '0) ? '0 : aval - crem_rem;
        rnd_prod  = div_rsp.quotient[EBB_W-1:0] * (EBB_W + ALIGN_W)'(aval);
        used_sum  = {1'b0, used_reg} + (ADDR_W + 1)'(ebb_reg);
        used_sub  = (used_reg < ADDR_W'(ebb_reg)) ? '0 : used_reg - ADDR_W'(ebb_reg);
        sat_count = (div_rsp.quotient > ADDR_W'(MAX_BLOCKS)) ? ADDR_W'(MAX_BLOCKS)
                                                              : div_rsp.quotient;
    end

    always_comb
    begin
        state_next       = state_reg;
        freed_count_next = freed_count_reg;
        fresh_next       = fresh_reg;
        block_count_next = block_count_reg;
        ebb_next         = ebb_reg;
        first_next       = first_reg;
        used_next        = used_reg;
        adj_next         = adj_reg;
        idx_next         = idx_reg;
        pop_next         = pop_reg;
        prod_next        = prod_reg;
        block_next       = block_reg;
        status_next      = status_reg;
        div_req          = '0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = freed_count_reg[IDX_W-1:0];
        ram_wr_data      = div_rsp.quotient[IDX_W-1:0];
        ram_rd_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    block_next  = '0;
                    status_next = ST_OK;
                    pop_next    = 1'b0;
                    state_next  = S_DONE;
                    unique case (op_t'(operation))
                        OP_ALLOC:
                        begin
                            if ({1'b0, request_bytes} > ebb_reg)
                            begin
                                status_next = ST_SIZE;
                            end
                            else if (request_alignment > aval)
                            begin
                                status_next = ST_ALIGN;
                            end
                            else if (freed_count_reg != '0)
                            begin
                                // pop the most recently freed block
                                ram_rd_en        = 1'b1;
                                freed_count_next = cnt_dec;
                                pop_next         = 1'b1;
                                state_next       = S_MUL;
                            end
                            else if (fresh_reg < block_count_reg)
                            begin
                                idx_next   = fresh_reg[IDX_W-1:0];
                                fresh_next = fresh_reg + 1'b1;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        OP_FREE:
                        begin
                            if (free_address != '0 && free_address >= first_reg)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = free_address - first_reg;
                                div_req.divisor  = ebb_reg;
                                state_next       = S_FDIV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = cfg_base_reg;
                            div_req.divisor  = EBB_W'(aval);
                            state_next       = S_CREM;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(mul_idx) * PROD_W'(ebb_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                block_next = first_reg + ADDR_W'(prod_reg);
                used_next  = used_sum[ADDR_W] ? '1 : used_sum[ADDR_W-1:0];
                state_next = S_DONE;
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                begin
                    // accept only an in-range block boundary with room on the stack
                    if (div_rsp.remainder == '0 &&
                        div_rsp.quotient < ADDR_W'(block_count_reg) &&
                        freed_count_reg < CNT_W'(MAX_BLOCKS))
                    begin
                        ram_wr_en        = 1'b1;
                        freed_count_next = freed_count_reg + 1'b1;
                        used_next        = used_sub;
                    end
                    state_next = S_DONE;
                end
            end
            S_CREM:
            begin
                if (div_rsp.done)
                begin
                    adj_next         = crem_adj;
                    first_next       = cfg_base_reg + ADDR_W'(crem_adj);
                    // round the block size up to a multiple of the alignment
                    div_req.start    = 1'b1;
                    div_req.dividend = ADDR_W'(req_one) + ADDR_W'(aval) - 1'b1;
                    div_req.divisor  = EBB_W'(aval);
                    state_next       = S_CRND;
                end
            end
            S_CRND:
            begin
                if (div_rsp.done)
                begin
                    ebb_next   = rnd_prod[EBB_W-1:0];
                    state_next = S_CSUB;
                end
            end
            S_CSUB:
            begin
                if (cfg_total_reg < ADDR_W'(adj_reg))
                begin
                    block_count_next = '0;
                    freed_count_next = '0;
                    fresh_next       = '0;
                    used_next        = '0;
                    state_next       = S_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = cfg_total_reg - ADDR_W'(adj_reg);
                    div_req.divisor  = ebb_reg;
                    state_next       = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    block_count_next = sat_count[CNT_W-1:0];
                    freed_count_next = '0;
                    fresh_next       = '0;
                    used_next        = '0;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg  <= ADDR_W'(RST_BASE);
            cfg_total_reg <= ADDR_W'(RST_TOTAL);
            cfg_block_reg <= REQ_W'(RST_BLOCK);
            cfg_align_reg <= ALIGN_W'(RST_ALIGN);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE:  cfg_base_reg  <= cfg_data;
                REG_TOTAL: cfg_total_reg <= cfg_data;
                REG_BLOCK: cfg_block_reg <= cfg_data[REQ_W-1:0];
                REG_ALIGN: cfg_align_reg <= cfg_data[ALIGN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            freed_count_reg <= '0;
            fresh_reg       <= '0;
            block_count_reg <= CNT_W'(RST_COUNT);
            ebb_reg         <= EBB_W'(RST_EBB);
            first_reg       <= ADDR_W'(RST_FIRST);
            used_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            freed_count_reg <= freed_count_next;
            fresh_reg       <= fresh_next;
            block_count_reg <= block_count_next;
            ebb_reg         <= ebb_next;
            first_reg       <= first_next;
            used_reg        <= used_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adj_reg    <= adj_next;
        idx_reg    <= idx_next;
        pop_reg    <= pop_next;
        prod_reg   <= prod_next;
        block_reg  <= block_next;
        status_reg <= status_next;
        if (load_out)
        begin
            out_block_reg  <= block_reg;
            out_status_reg <= status_reg;
            out_used_reg   <= used_reg;
        end
    end

    fbpa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_freed_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cnt_dec[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign block_address = out_block_reg;
    assign status        = out_status_reg;
    assign used_bytes    = out_used_reg;

    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        freed_count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("freed stack count beyond pool capacity");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= block_count_reg)
        else $error("fresh block index beyond block count");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_FDIV || state_reg == S_CREM ||
                          state_reg == S_CRND || state_reg == S_CDIV))
        else $error("divider finished outside a waiting state");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not presented after completion");

    a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_block_reg == '0)
        else $error("block address given with a failure status");

endmodule
